// ===== rtl/tlprc_pkg.sv =====
// Shared widths, codes and configuration types for the long-press right click core.
package tlprc_pkg;

   // Width of one scaled or raw axis value.
   localparam int AXIS_W = 16;
   // Width of the contact identifier.
   localparam int CID_W = 8;
   // Width of the orientation register.
   localparam int ORIENT_W = 3;
   // Width of the button code.
   localparam int BTN_W = 2;
   // Width of the configuration register index.
   localparam int CSR_IDX_W = 3;
   // Width of the hover counter.
   localparam int HOVER_W = 2;

   // Full scale of an axis after scaling.
   localparam logic [AXIS_W-1:0] FULL_SCALE = 16'hFFFF;
   // Last hover count that still reports no button.
   localparam logic [HOVER_W-1:0] HOVER_LAST = 2'd2;

   // Reset values of the configuration registers.
   localparam logic [AXIS_W-1:0]   RST_MAX_X  = 16'd4095;
   localparam logic [AXIS_W-1:0]   RST_MAX_Y  = 16'd4095;
   localparam logic [ORIENT_W-1:0] RST_ORIENT = 3'd0;
   localparam logic [AXIS_W-1:0]   RST_RANGE  = 16'd1000;
   localparam logic [AXIS_W-1:0]   RST_COUNT  = 16'd35;

   // Orientation bits.
   localparam int ORIENT_SWAP  = 0;
   localparam int ORIENT_INV_X = 1;
   localparam int ORIENT_INV_Y = 2;

   // Button codes.
   localparam logic [BTN_W-1:0] BTN_NONE     = 2'd0;
   localparam logic [BTN_W-1:0] BTN_LEFT     = 2'd1;
   localparam logic [BTN_W-1:0] BTN_RIGHT    = 2'd2;
   localparam logic [BTN_W-1:0] BTN_RESERVED = 2'd3;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_MAX_X  = 3'd0,
      REG_MAX_Y  = 3'd1,
      REG_ORIENT = 3'd2,
      REG_RANGE  = 3'd3,
      REG_COUNT  = 3'd4
   } reg_index_type;

   // Settings used by the gesture tracker.
   typedef struct packed {
      logic [ORIENT_W-1:0] orientation;
      logic [AXIS_W-1:0]   press_range;
      logic [AXIS_W-1:0]   press_count;
   } gesture_cfg_type;

endpackage

// ===== rtl/touch_long_press_right_click_core.sv =====
// An accepted report runs through the bit-serial dividers and the tracker into the
// result register when it is free; a result still waiting holds the core until it
// is taken, and no new report is accepted until the last one has been committed.
// A report with both tips clear is dropped in its accept cycle and gives no result.
// Reset (synchronous, active high) restores the register defaults and clears
// the tracker state and both handshakes.
// Top level of the long-press right click core: handshakes, registers, sequencing.
module touch_long_press_right_click_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [tlprc_pkg::AXIS_W-1:0]           req_raw_x,
   input  logic [tlprc_pkg::AXIS_W-1:0]           req_raw_y,
   input  logic                                   req_tip_now,
   input  logic                                   req_tip_before,
   input  logic [tlprc_pkg::CID_W-1:0]            req_contact_id,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [tlprc_pkg::AXIS_W-1:0]           rsp_out_x,
   output logic [tlprc_pkg::AXIS_W-1:0]           rsp_out_y,
   output logic [tlprc_pkg::BTN_W-1:0]            rsp_button_state,
   output logic [tlprc_pkg::CID_W-1:0]            rsp_out_contact_id,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [tlprc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [tlprc_pkg::AXIS_W-1:0]           csr_wdata
);
   import tlprc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type         state_ff;
   logic [AXIS_W-1:0] max_x_ff;
   logic [AXIS_W-1:0] max_y_ff;
   gesture_cfg_type   cfg_ff;
   logic              tip_now_ff;
   logic              tip_before_ff;
   logic [CID_W-1:0]  cid_ff;
   logic              rsp_valid_ff;
   logic [AXIS_W-1:0] rsp_x_ff;
   logic [AXIS_W-1:0] rsp_y_ff;
   logic [BTN_W-1:0]  rsp_btn_ff;
   logic [CID_W-1:0]  rsp_cid_ff;
   logic              accept;
   logic              start;
   logic              div_done;
   logic              div_done_y;
   logic              commit;
   logic [AXIS_W-1:0] quo_x;
   logic [AXIS_W-1:0] quo_y;
   logic [AXIS_W-1:0] trk_x;
   logic [AXIS_W-1:0] trk_y;
   logic [BTN_W-1:0]  trk_btn;

   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign start     = accept && (req_tip_now || req_tip_before);
   assign commit    = (state_ff == ST_OUT) && (!rsp_valid_ff || rsp_ready);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_x_ff            <= RST_MAX_X;
         max_y_ff            <= RST_MAX_Y;
         cfg_ff.orientation  <= RST_ORIENT;
         cfg_ff.press_range  <= RST_RANGE;
         cfg_ff.press_count  <= RST_COUNT;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_MAX_X:  max_x_ff           <= csr_wdata;
            REG_MAX_Y:  max_y_ff           <= csr_wdata;
            REG_ORIENT: cfg_ff.orientation <= csr_wdata[ORIENT_W-1:0];
            REG_RANGE:  cfg_ff.press_range <= csr_wdata;
            REG_COUNT:  cfg_ff.press_count <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // One divider lane per axis.
   tlprc_div u_div_x (
      .clock (clock),
      .reset (reset),
      .start (start),
      .raw   (req_raw_x),
      .max   (max_x_ff),
      .done  (div_done),
      .quo   (quo_x)
   );

   tlprc_div u_div_y (
      .clock (clock),
      .reset (reset),
      .start (start),
      .raw   (req_raw_y),
      .max   (max_y_ff),
      .done  (div_done_y),
      .quo   (quo_y)
   );

   tlprc_track u_track (
      .clock      (clock),
      .reset      (reset),
      .commit     (commit),
      .cfg        (cfg_ff),
      .x_scaled   (quo_x),
      .y_scaled   (quo_y),
      .tip_now    (tip_now_ff),
      .tip_before (tip_before_ff),
      .out_x      (trk_x),
      .out_y      (trk_y),
      .buttons    (trk_btn)
   );

   // Sequencer, item fields carried alongside the division, and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  state_ff      <= ST_DIV;
                  tip_now_ff    <= req_tip_now;
                  tip_before_ff <= req_tip_before;
                  cid_ff        <= req_contact_id;
               end
            end
            ST_DIV: begin
               if (div_done) begin
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (commit) begin
                  state_ff   <= ST_IDLE;
                  rsp_x_ff   <= trk_x;
                  rsp_y_ff   <= trk_y;
                  rsp_btn_ff <= trk_btn;
                  rsp_cid_ff <= cid_ff;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         // A new result may replace one that leaves in the same cycle.
         if (commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_x          = rsp_x_ff;
   assign rsp_out_y          = rsp_y_ff;
   assign rsp_button_state   = rsp_btn_ff;
   assign rsp_out_contact_id = rsp_cid_ff;

`ifndef SYNTHESIS
   // Both divider lanes finish together, and only while a division runs.
   assert property (@(posedge clock) disable iff (reset)
      (div_done == div_done_y) && (!div_done || state_ff == ST_DIV))
      else $error("divider lanes out of step");

   // A committed item shows up as a valid result in the next cycle.
   assert property (@(posedge clock) disable iff (reset) commit |=> rsp_valid)
      else $error("committed item not presented");

   // A report with both tips clear starts no work.
   assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tip_now && !req_tip_before) |=> (state_ff == ST_IDLE))
      else $error("dropped item started a division");

   // The reserved button code is never reported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_button_state != BTN_RESERVED))
      else $error("reserved button code reported");
`endif

endmodule

// ===== rtl/tlprc_div.sv =====
// Bit-serial restoring divider that scales one raw axis to full scale.
module tlprc_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [tlprc_pkg::AXIS_W-1:0]  raw,
   input  logic [tlprc_pkg::AXIS_W-1:0]  max,
   output logic                          done,
   output logic [tlprc_pkg::AXIS_W-1:0]  quo
);
   import tlprc_pkg::*;

   localparam int CNT_W = $clog2(AXIS_W + 1);

   logic [2*AXIS_W-1:0] prod;
   logic [AXIS_W:0]     trial;
   logic [AXIS_W:0]     diff;
   logic                fits;
   logic [AXIS_W-1:0]   rem_ff;
   logic [AXIS_W-1:0]   rem_in;
   logic [AXIS_W-1:0]   num_ff;
   logic [AXIS_W-1:0]   quo_ff;
   logic                sat_ff;
   logic [CNT_W-1:0]    cnt_ff;
   logic                done_ff;

   // Dividend is raw times full scale, formed as a shift and a subtract.
   assign prod = {raw, {AXIS_W{1'b0}}} - {{AXIS_W{1'b0}}, raw};

   // One quotient bit per cycle: bring down the next dividend bit and try the divisor.
   assign trial  = {rem_ff, num_ff[AXIS_W-1]};
   assign diff   = trial - {1'b0, max};
   assign fits   = (trial >= {1'b0, max});
   assign rem_in = fits ? diff[AXIS_W-1:0] : trial[AXIS_W-1:0];

   // Iteration counter and completion pulse.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= CNT_W'(AXIS_W);
         end else if (cnt_ff != '0) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               done_ff <= 1'b1;
            end
         end
      end
   end

   // Remainder, dividend and quotient shift registers. A quotient that would not
   // fit in the axis width (upper dividend half at or above the divisor) saturates,
   // which also covers a zero divisor.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= prod[2*AXIS_W-1:AXIS_W];
         num_ff <= prod[AXIS_W-1:0];
         sat_ff <= (prod[2*AXIS_W-1:AXIS_W] >= max);
      end else if (cnt_ff != '0) begin
         rem_ff <= rem_in;
         num_ff <= {num_ff[AXIS_W-2:0], 1'b0};
         quo_ff <= {quo_ff[AXIS_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = sat_ff ? FULL_SCALE : quo_ff;

endmodule

// ===== rtl/tlprc_track.sv =====
// Orientation, long-press detection and button state for one finger.
module tlprc_track (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               commit,
   input  tlprc_pkg::gesture_cfg_type         cfg,
   input  logic [tlprc_pkg::AXIS_W-1:0]       x_scaled,
   input  logic [tlprc_pkg::AXIS_W-1:0]       y_scaled,
   input  logic                               tip_now,
   input  logic                               tip_before,
   output logic [tlprc_pkg::AXIS_W-1:0]       out_x,
   output logic [tlprc_pkg::AXIS_W-1:0]       out_y,
   output logic [tlprc_pkg::BTN_W-1:0]        buttons
);
   import tlprc_pkg::*;

   logic [AXIS_W-1:0]  ref_x_ff;
   logic [AXIS_W-1:0]  ref_y_ff;
   logic [AXIS_W-1:0]  still_ff;
   logic               armed_ff;
   logic [HOVER_W-1:0] hover_ff;
   logic [AXIS_W-1:0]  ref_x_in;
   logic [AXIS_W-1:0]  ref_y_in;
   logic [AXIS_W-1:0]  still_in;
   logic               armed_in;
   logic [HOVER_W-1:0] hover_in;
   logic [AXIS_W-1:0]  sw_x;
   logic [AXIS_W-1:0]  sw_y;
   logic [AXIS_W-1:0]  dx;
   logic [AXIS_W-1:0]  dy;
   logic [AXIS_W:0]    mag_x;
   logic [AXIS_W:0]    mag_y;
   logic               is_still;
   logic [AXIS_W-1:0]  still_inc;
   logic               lift;

   // Swap first, then invert each axis.
   assign sw_x  = cfg.orientation[ORIENT_SWAP] ? y_scaled : x_scaled;
   assign sw_y  = cfg.orientation[ORIENT_SWAP] ? x_scaled : y_scaled;
   assign out_x = cfg.orientation[ORIENT_INV_X] ? (FULL_SCALE - sw_x) : sw_x;
   assign out_y = cfg.orientation[ORIENT_INV_Y] ? (FULL_SCALE - sw_y) : sw_y;

   // Wrapped distance from the reference point, taken as a magnitude.
   assign dx    = ref_x_ff - out_x;
   assign dy    = ref_y_ff - out_y;
   assign mag_x = dx[AXIS_W-1] ? ((AXIS_W+1)'(1) << AXIS_W) - {1'b0, dx} : {1'b0, dx};
   assign mag_y = dy[AXIS_W-1] ? ((AXIS_W+1)'(1) << AXIS_W) - {1'b0, dy} : {1'b0, dy};
   assign is_still  = (mag_x < {1'b0, cfg.press_range}) && (mag_y < {1'b0, cfg.press_range});
   assign still_inc = still_ff + 1'b1;
   assign lift      = !tip_now && tip_before;

   // Next state of the long-press tracker and the reported button.
   always_comb begin
      ref_x_in = ref_x_ff;
      ref_y_in = ref_y_ff;
      still_in = still_ff;
      armed_in = armed_ff;
      hover_in = hover_ff;
      if (!armed_ff) begin
         if (is_still) begin
            still_in = still_inc;
            if (still_inc >= cfg.press_count) begin
               ref_x_in = '0;
               ref_y_in = '0;
               still_in = '0;
               armed_in = 1'b1;
            end
         end else begin
            ref_x_in = out_x;
            ref_y_in = out_y;
            still_in = '0;
         end
      end
      if (hover_ff <= HOVER_LAST) begin
         buttons  = BTN_NONE;
         hover_in = hover_ff + 1'b1;
      end else if (armed_in && tip_now) begin
         buttons = BTN_RIGHT;
      end else begin
         buttons = tip_now ? BTN_LEFT : BTN_NONE;
      end
      // A lift is reported with the old state, then ends the gesture.
      if (lift) begin
         hover_in = '0;
         armed_in = 1'b0;
      end
   end

   // Tracker state, updated once per reported item.
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_x_ff <= '0;
         ref_y_ff <= '0;
         still_ff <= '0;
         armed_ff <= 1'b0;
         hover_ff <= '0;
      end else if (commit) begin
         ref_x_ff <= ref_x_in;
         ref_y_ff <= ref_y_in;
         still_ff <= still_in;
         armed_ff <= armed_in;
         hover_ff <= hover_in;
      end
   end

endmodule
